@@ rtl/ppmfd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppmfd_pkg
// Shared widths, register indexes and reset values of the PPM frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ppmfd_pkg;

  localparam int TimeW  = 16;
  localparam int ScaleW = 7;
  localparam int ChanW  = 3;
  localparam int WidthW = 23;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam int ChannelsDefault = 8;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgSyncGap   = 2'd0;
  localparam cfg_idx_t CfgMinGap    = 2'd1;
  localparam cfg_idx_t CfgMaxGap    = 2'd2;
  localparam cfg_idx_t CfgTickScale = 2'd3;

  localparam logic [TimeW-1:0]  SyncGapReset   = 16'd500;
  localparam logic [TimeW-1:0]  MinGapReset    = 16'd80;
  localparam logic [TimeW-1:0]  MaxGapReset    = 16'd220;
  localparam logic [ScaleW-1:0] TickScaleReset = 7'd10;

endpackage

`default_nettype wire

@@ rtl/ppmfd_in_if.sv @@
// ----------------------------------------------------------------------------
// ppmfd_in_if
// Capture timestamp channel: valid/ready handshake with one timer word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppmfd_in_if;
  logic                          valid;
  logic                          ready;
  logic [ppmfd_pkg::TimeW-1:0]   capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

`default_nettype wire

@@ rtl/ppmfd_out_if.sv @@
// ----------------------------------------------------------------------------
// ppmfd_out_if
// Channel width channel: valid/ready handshake with index, width, last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppmfd_out_if;
  logic                           valid;
  logic                           ready;
  logic [ppmfd_pkg::ChanW-1:0]    channel;
  logic [ppmfd_pkg::WidthW-1:0]   width_us;
  logic                           last_channel;

  modport source (output valid, output channel, output width_us, output last_channel,
                  input ready);
  modport sink   (input valid, input channel, input width_us, input last_channel,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/ppm_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// ppm_frame_decoder
// Decodes a PPM pulse train from rising-edge timer captures into channel
// widths in microseconds.
//
// in_ch takes one 16-bit capture word per rising edge. The gap to the
// previous capture is checked against the sync limit and the pulse window.
// When the last channel of a good frame arrives, out_ch delivers CHANNELS
// words, channel 0 first, the final one flagged by last_channel.
// An edge that ends no frame passes through accept, gap and check. An edge
// that completes a frame then emits every width in turn: each width needs one
// gap store read and one pass through the shared 16x7 multiplier, which
// loads the output register. in_ch is not ready during that time.
// A word waiting in the output register does not block the next capture.
// When out_ch stalls, the emit sequence holds until the register frees.
// cfg_* writes set sync_gap, min_gap, max_gap and tick_scale; write only
// while the block is idle. Reset returns the registers to their defaults,
// clears the phase, the bad-frame flag and the previous capture time.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_frame_decoder #(
  parameter int CHANNELS = ppmfd_pkg::ChannelsDefault
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  ppmfd_in_if.sink                                in_ch,
  ppmfd_out_if.source                             out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [ppmfd_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [ppmfd_pkg::CfgDataW-1:0]     cfg_data
);

  localparam int PhW = $clog2(CHANNELS + 1);
  localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [PhW-1:0] LastPhase = PhW'(CHANNELS);
  localparam logic [AW-1:0]  LastIdx   = AW'(CHANNELS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GAP  = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;

  logic [2:0]                        state_r, state_nxt;
  logic [ppmfd_pkg::TimeW-1:0]       sync_gap_r, min_gap_r, max_gap_r;
  logic [ppmfd_pkg::ScaleW-1:0]      tick_scale_r;
  logic [ppmfd_pkg::TimeW-1:0]       prev_r, prev_nxt;
  logic [ppmfd_pkg::TimeW-1:0]       gap_r, gap_nxt;
  logic [PhW-1:0]                    phase_r, phase_nxt;
  logic                              bad_r, bad_nxt;
  logic [AW-1:0]                     rd_idx_r, rd_idx_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [ppmfd_pkg::ChanW-1:0]       out_chan_r, out_chan_nxt;
  logic [ppmfd_pkg::WidthW-1:0]      out_width_r, out_width_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                              in_acc;
  logic                              out_free;
  logic [ppmfd_pkg::TimeW-1:0]       diff;
  logic                              is_sync;
  logic                              out_window;
  logic                              bad_upd;
  logic [PhW-1:0]                    ph;
  logic                              emit;
  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  logic [ppmfd_pkg::TimeW-1:0]       ram_rdata;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.channel      = out_chan_r;
  assign out_ch.width_us     = out_width_r;
  assign out_ch.last_channel = out_last_r;
  assign out_free            = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_gap_r   <= ppmfd_pkg::SyncGapReset;
      min_gap_r    <= ppmfd_pkg::MinGapReset;
      max_gap_r    <= ppmfd_pkg::MaxGapReset;
      tick_scale_r <= ppmfd_pkg::TickScaleReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppmfd_pkg::CfgSyncGap:   sync_gap_r   <= cfg_data;
        ppmfd_pkg::CfgMinGap:    min_gap_r    <= cfg_data;
        ppmfd_pkg::CfgMaxGap:    max_gap_r    <= cfg_data;
        ppmfd_pkg::CfgTickScale: tick_scale_r <= cfg_data[ppmfd_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  assign diff       = in_ch.capture_time - prev_r;
  assign is_sync    = (gap_r > sync_gap_r);
  assign out_window = (gap_r < min_gap_r) || (gap_r > max_gap_r);
  assign bad_upd    = is_sync ? 1'b0 : (bad_r || out_window);
  assign ph         = is_sync ? '0 : phase_r;
  assign emit       = (state_r == S_EVAL) && (ph == LastPhase) && !bad_upd;
  assign ram_we     = (state_r == S_EVAL) && (ph != '0);
  assign ram_waddr  = AW'(ph - PhW'(1));

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    gap_nxt       = gap_r;
    phase_nxt     = phase_r;
    bad_nxt       = bad_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_chan_nxt  = out_chan_r;
    out_width_nxt = out_width_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          prev_nxt  = in_ch.capture_time;
          // wrap drops one tick, as 0xFFFF - previous + now
          gap_nxt   = (in_ch.capture_time > prev_r) ? diff : diff - 16'd1;
          state_nxt = S_GAP;
        end
      end
      S_GAP: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        bad_nxt    = bad_upd;
        phase_nxt  = (ph == LastPhase) ? '0 : ph + PhW'(1);
        rd_idx_nxt = '0;
        state_nxt  = emit ? S_RD : S_IDLE;
      end
      S_RD: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_chan_nxt  = ppmfd_pkg::ChanW'(rd_idx_r);
          out_width_nxt = ppmfd_pkg::WidthW'(ram_rdata) *
                          ppmfd_pkg::WidthW'(tick_scale_r);
          out_last_nxt  = (rd_idx_r == LastIdx);
          rd_idx_nxt    = rd_idx_r + AW'(1);
          state_nxt     = (rd_idx_r == LastIdx) ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      phase_r     <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      phase_r     <= phase_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
      rd_idx_r    <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gap_r       <= gap_nxt;
    out_chan_r  <= out_chan_nxt;
    out_width_r <= out_width_nxt;
    out_last_r  <= out_last_nxt;
  end

  ppmfd_ram #(
    .Width(ppmfd_pkg::TimeW),
    .Depth(CHANNELS)
  ) u_gap_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(gap_r),
    .raddr(rd_idx_r),
    .rdata(ram_rdata)
  );

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= LastPhase)
    else $error("phase beyond channel count");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_chan_r == ppmfd_pkg::ChanW'(CHANNELS - 1)))
    else $error("last flag on wrong channel");

  a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (state_r == S_RD) && (rd_idx_r == '0))
    else $error("emit sequence did not start at channel 0");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> !in_acc)
    else $error("capture accepted during emit");

endmodule

`default_nettype wire

@@ rtl/ppmfd_ram.sv @@
// ----------------------------------------------------------------------------
// ppmfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmfd_ram #(
  parameter int Width = 16,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ppm_frame_decoder. Capture words go in on in_ch
// with random pauses; width words come back on out_ch under random and long
// stalls. A frame model in the bench tracks gaps, phase and the bad-frame
// flag, and queues the eight widths each good frame produces. Each width word
// is compared field by field with the oldest queued one. Directed frames come
// first, then random frames and noise under several limit settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCh          = ppmfd_pkg::ChannelsDefault;
  localparam int SettleCycles = 40;

  typedef struct packed {
    logic [ppmfd_pkg::ChanW-1:0]  channel;
    logic [ppmfd_pkg::WidthW-1:0] width_us;
    logic                         last_channel;
  } width_word_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  ppmfd_pkg::cfg_idx_t            cfg_index;
  logic [ppmfd_pkg::CfgDataW-1:0] cfg_data;

  ppmfd_in_if  in_ch ();
  ppmfd_out_if out_ch ();

  ppm_frame_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // frame model state and limits
  logic [ppmfd_pkg::TimeW-1:0]  lim_sync   = ppmfd_pkg::SyncGapReset;
  logic [ppmfd_pkg::TimeW-1:0]  lim_min    = ppmfd_pkg::MinGapReset;
  logic [ppmfd_pkg::TimeW-1:0]  lim_max    = ppmfd_pkg::MaxGapReset;
  logic [ppmfd_pkg::ScaleW-1:0] tick_mult  = ppmfd_pkg::TickScaleReset;
  logic [ppmfd_pkg::TimeW-1:0]  last_stamp = '0;
  int                           frame_phase = 0;
  bit                           frame_bad = 1'b0;
  logic [ppmfd_pkg::TimeW-1:0]  chan_gap [NCh];

  width_word_t expected_widths [$];

  logic [ppmfd_pkg::TimeW-1:0] stamp_now = '0;
  int               edges_sent = 0;
  int               fail_count = 0;
  bit               src_idle = 1'b1;
  bit               sink_idle = 1'b1;
  int               hold_cycles = 0;
  int               stall_left = 0;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_pause(bit on);
    return on ? int'($urandom_range(11, 0)) : 0;
  endfunction

  task automatic decode_edge(input logic [ppmfd_pkg::TimeW-1:0] now);
    logic [ppmfd_pkg::TimeW-1:0] gap;
    width_word_t                 w;
    if (now > last_stamp) gap = now - last_stamp;
    else gap = 16'hFFFF - last_stamp + now;
    if (gap > lim_sync) begin
      frame_phase = 0;
      frame_bad   = 1'b0;
    end else if (gap < lim_min || gap > lim_max) begin
      frame_bad = 1'b1;
    end
    if (frame_phase >= 1) begin
      chan_gap[frame_phase-1] = gap;
      if (frame_phase == NCh && !frame_bad) begin
        for (int k = 0; k < NCh; k++) begin
          w.channel      = ppmfd_pkg::ChanW'(k);
          w.width_us     = ppmfd_pkg::WidthW'(chan_gap[k]) *
                           ppmfd_pkg::WidthW'(tick_mult);
          w.last_channel = (k == NCh - 1);
          expected_widths.push_back(w);
        end
      end
    end
    last_stamp  = now;
    frame_phase = (frame_phase == NCh) ? 0 : frame_phase + 1;
  endtask

  task automatic send_capture(input logic [ppmfd_pkg::TimeW-1:0] stamp);
    int pause;
    pause = draw_pause(src_idle);
    if (pause > 0) begin
      in_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.capture_time <= stamp;
    do @(posedge clk); while (!in_ch.ready);
    decode_edge(stamp);
    edges_sent++;
  endtask

  task automatic send_gap(input logic [ppmfd_pkg::TimeW-1:0] g);
    stamp_now = stamp_now + g;
    send_capture(stamp_now);
  endtask

  task automatic send_frame(input int n_ch, input bit corrupt);
    int                          lo;
    int                          bad_at;
    logic [ppmfd_pkg::TimeW-1:0] g;
    lo = int'(lim_sync) + 2;
    if (lo > 65535) send_capture(stamp_now);
    else send_gap(ppmfd_pkg::TimeW'($urandom_range(65535, lo)));
    bad_at = corrupt ? int'($urandom_range(n_ch - 1, 0)) : -1;
    for (int i = 0; i < n_ch; i++) begin
      if (i == bad_at) g = ppmfd_pkg::TimeW'($urandom);
      else if (lim_min <= lim_max) g = ppmfd_pkg::TimeW'($urandom_range(lim_max, lim_min));
      else g = ppmfd_pkg::TimeW'($urandom);
      send_gap(g);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_widths.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input ppmfd_pkg::cfg_idx_t idx,
                           input logic [ppmfd_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ppmfd_pkg::CfgSyncGap:   lim_sync  = data;
      ppmfd_pkg::CfgMinGap:    lim_min   = data;
      ppmfd_pkg::CfgMaxGap:    lim_max   = data;
      ppmfd_pkg::CfgTickScale: tick_mult = data[ppmfd_pkg::ScaleW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [15:0] sync_g, input logic [15:0] min_g,
                            input logic [15:0] max_g, input logic [15:0] scale_raw);
    wait_idle();
    write_reg(ppmfd_pkg::CfgSyncGap, sync_g);
    write_reg(ppmfd_pkg::CfgMinGap, min_g);
    write_reg(ppmfd_pkg::CfgMaxGap, max_g);
    write_reg(ppmfd_pkg::CfgTickScale, scale_raw);
  endtask

  task automatic check_width_word();
    width_word_t exp_w;
    if (expected_widths.size() == 0) begin
      $error("unexpected width word: channel %0d width_us %0d last_channel %0d",
             out_ch.channel, out_ch.width_us, out_ch.last_channel);
      fail_count++;
    end else begin
      exp_w = expected_widths.pop_front();
      if (out_ch.channel !== exp_w.channel) begin
        $error("channel: expected %0d, got %0d", exp_w.channel, out_ch.channel);
        fail_count++;
      end
      if (out_ch.width_us !== exp_w.width_us) begin
        $error("width_us: expected %0d, got %0d", exp_w.width_us, out_ch.width_us);
        fail_count++;
      end
      if (out_ch.last_channel !== exp_w.last_channel) begin
        $error("last_channel: expected %0d, got %0d", exp_w.last_channel,
               out_ch.last_channel);
        fail_count++;
      end
    end
  endtask

  // width word sink with random stalls and an external hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_width_word();
        stall_left = draw_pause(sink_idle);
      end else if (!out_ch.ready && stall_left > 0) begin
        stall_left--;
      end
      out_ch.ready <= (hold_cycles == 0) && (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  task automatic test_good_frame();
    set_limits(ppmfd_pkg::SyncGapReset, ppmfd_pkg::MinGapReset, ppmfd_pkg::MaxGapReset,
               16'(ppmfd_pkg::TickScaleReset));
    // sync lands near the top of the timer so channel gaps wrap through zero
    stamp_now = 16'hFF00;
    send_capture(stamp_now);
    for (int i = 0; i < NCh; i++) send_gap((i % 2) ? 16'd220 : 16'd80);
  endtask

  task automatic test_window_errors();
    // short gap early in the frame; flag holds through the final phase
    send_gap(16'd600);
    for (int i = 0; i < NCh; i++) send_gap((i == 1) ? 16'd79 : 16'd150);
    // long gap at the final phase only
    send_gap(16'd600);
    for (int i = 0; i < NCh; i++) send_gap((i == NCh - 1) ? 16'd221 : 16'd150);
  endtask

  task automatic test_equal_stamps();
    send_capture(stamp_now);
    stamp_now = 16'hFFFF;
    send_capture(stamp_now);
    stamp_now = 16'h0000;
    send_capture(stamp_now);
  endtask

  task automatic test_random_traffic();
    int start;
    int quota;
    int r;
    for (int ph = 0; ph < 8; ph++) begin
      quota = 20;
      case (ph)
        0: set_limits(ppmfd_pkg::SyncGapReset, ppmfd_pkg::MinGapReset,
                      ppmfd_pkg::MaxGapReset, 16'(ppmfd_pkg::TickScaleReset));
        1: set_limits(16'hFFFE, 16'h0000, 16'hFFFF, 16'h007F);
        2: begin
          set_limits(16'hFFFF, 16'h0000, 16'h0000, 16'h007F);
          quota = 10;
        end
        3: set_limits(16'($urandom_range(40000, 700)), 16'($urandom_range(200, 0)),
                      16'($urandom_range(900, 200)), 16'($urandom));
        4: set_limits(16'd1000, 16'd300, 16'd100, 16'hFF81);
        5: begin
          set_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000);
          quota = 10;
        end
        6: set_limits(16'd2000, 16'd0, 16'd2000, 16'h0000);
        default: set_limits(16'($urandom_range(3000, 600)), 16'($urandom_range(100, 20)),
                            16'($urandom_range(500, 150)), 16'($urandom));
      endcase
      src_idle  = (ph % 3 == 1) ? 1'b0 : 1'($urandom);
      sink_idle = (ph % 3 == 1) ? 1'b0 : 1'b1;
      start = edges_sent;
      while (edges_sent - start < quota) begin
        r = $urandom_range(99, 0);
        if (r < 75) begin
          send_frame(NCh, 1'b0);
        end else if (r < 88) begin
          send_frame($urandom_range(NCh, 1), 1'b1);
        end else begin
          repeat ($urandom_range(3, 1)) begin
            stamp_now = ppmfd_pkg::TimeW'($urandom);
            send_capture(stamp_now);
          end
        end
      end
    end
  endtask

  task automatic test_output_backpressure();
    set_limits(ppmfd_pkg::SyncGapReset, ppmfd_pkg::MinGapReset, ppmfd_pkg::MaxGapReset,
               16'd37);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_cycles <= 300;
    repeat (3) send_frame(NCh, 1'b0);
    wait_idle();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = ppmfd_pkg::CfgSyncGap;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.capture_time = '0;
    out_ch.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_good_frame();
    test_window_errors();
    test_equal_stamps();
    test_random_traffic();
    test_output_backpressure();

    wait_idle();
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ppmfd_pkg.sv
rtl/ppmfd_in_if.sv
rtl/ppmfd_out_if.sv
rtl/ppmfd_ram.sv
rtl/ppm_frame_decoder.sv
tb/tb_top.sv
